FILE: design/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants of the fragment deframer with byte checksum.
// ----------------------------------------------------------------------------
package fdc_pkg;

    localparam int          HEADER_BYTES   = 20;
    localparam int          HEADER_WORDS   = 5;
    localparam int          FRAME_BYTES_DEF = 2048;
    localparam logic [31:0] MAGIC_RESET    = 32'hbadc0ded;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_MAGIC      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BYTES_SIGNED      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BIG_ENDIAN = 2'd2;

    localparam int HW_MAGIC    = 0;
    localparam int HW_FRAG_LEN = 1;
    localparam int HW_TOTAL    = 2;
    localparam int HW_INFO     = 3;
    localparam int HW_CHECKSUM = 4;

    typedef enum logic [2:0] {
        STATUS_OK             = 3'd0,
        STATUS_BAD_MAGIC      = 3'd1,
        STATUS_TOTAL_MISMATCH = 3'd2,
        STATUS_BAD_LENGTH     = 3'd3,
        STATUS_BAD_CHECKSUM   = 3'd4,
        STATUS_TRUNCATED      = 3'd5
    } status_t;

    typedef struct packed {
        logic [31:0] message_length;
        logic [31:0] message_info;
        status_t     status;
        logic        message_done;
        logic        payload_valid;
        logic [7:0]  payload_byte;
    } fdc_result_t;

endpackage

FILE: design/fdc_core.sv
// ----------------------------------------------------------------------------
// fdc_core
// Frame parser state: header assembly and checks, payload checksum,
// fragment reassembly. One item is consumed on each step.
// ----------------------------------------------------------------------------
module fdc_core
    import fdc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  step,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  res_valid,
    output fdc_result_t           res
);

    localparam int          SEEN_W   = $clog2(FRAME_BYTES);
    localparam logic [31:0] MAX_FRAG = 32'(FRAME_BYTES - HEADER_BYTES);
    localparam logic [4:0]  HDR_LAST = 5'(HEADER_BYTES - 1);

    logic [31:0] magic_reg;
    logic        signed_reg;
    logic        big_endian_reg;

    logic [4:0]        pos_reg,     pos_next;
    logic              payload_reg, payload_next;
    logic              discard_reg, discard_next;
    logic [31:0]       wa_reg,      wa_next;
    logic [SEEN_W-1:0] seen_reg,    seen_next;
    logic [31:0]       sum_reg,     sum_next;
    logic [31:0]       total_reg,   total_next;
    logic [31:0]       recv_reg,    recv_next;
    logic [31:0]       info_reg,    info_next;
    logic [31:0]       hw_reg [HEADER_WORDS];

    logic              hw_we;
    logic [31:0]       asm_word;
    logic [31:0]       byte_ext;
    logic [31:0]       sum_new;
    logic [SEEN_W-1:0] seen_inc;
    logic              short_frag;
    logic [31:0]       room;
    logic [31:0]       chk_word;
    logic [31:0]       fin_sum;
    logic [31:0]       fin_total;
    logic [31:0]       fin_recv;
    logic              fin_ok;
    logic              fin_done;
    logic              do_fail;
    logic              fail_last;
    status_t           fail_status;
    logic              do_finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg      <= MAGIC_RESET;
            signed_reg     <= 1'b1;
            big_endian_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_HEADER_MAGIC:      magic_reg      <= cfg_wdata;
                REG_BYTES_SIGNED:      signed_reg     <= cfg_wdata[0];
                REG_HEADER_BIG_ENDIAN: big_endian_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign asm_word = big_endian_reg ? {wa_reg[23:0], in_byte}
                                     : wa_reg | ({24'd0, in_byte} << {pos_reg[1:0], 3'b000});
    assign byte_ext = (signed_reg && in_byte[7]) ? {24'hffffff, in_byte} : {24'd0, in_byte};
    assign sum_new  = sum_reg + byte_ext;
    assign seen_inc = seen_reg + 1'b1;
    assign short_frag = {{(32-SEEN_W){1'b0}}, seen_inc} < hw_reg[HW_FRAG_LEN];
    assign room     = hw_reg[HW_TOTAL] - recv_reg;
    assign chk_word = payload_reg ? hw_reg[HW_CHECKSUM] : asm_word;
    assign fin_sum  = payload_reg ? sum_new : 32'd0;
    assign fin_total = payload_reg ? total_reg : hw_reg[HW_TOTAL];
    assign fin_recv = recv_reg + hw_reg[HW_FRAG_LEN];
    assign fin_ok   = fin_sum == chk_word;
    assign fin_done = fin_recv >= fin_total;

    always_comb begin
        pos_next     = pos_reg;
        payload_next = payload_reg;
        discard_next = discard_reg;
        wa_next      = wa_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        total_next   = total_reg;
        recv_next    = recv_reg;
        info_next    = info_reg;
        hw_we        = 1'b0;
        do_fail      = 1'b0;
        fail_last    = in_last;
        fail_status  = STATUS_OK;
        do_finish    = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        if (step) begin
            if (discard_reg) begin
                if (in_last) begin
                    discard_next = 1'b0;
                end
            end else if (!payload_reg) begin
                wa_next  = asm_word;
                pos_next = pos_reg + 1'b1;
                if (pos_reg[1:0] == 2'd3) begin
                    hw_we   = 1'b1;
                    wa_next = 32'd0;
                end
                if (pos_reg != HDR_LAST) begin
                    if (in_last) begin
                        do_fail     = 1'b1;
                        fail_status = STATUS_TRUNCATED;
                    end
                end else if (hw_reg[HW_MAGIC] != magic_reg) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_BAD_MAGIC;
                end else if (total_reg != 32'd0 && total_reg != hw_reg[HW_TOTAL]) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_TOTAL_MISMATCH;
                end else if (hw_reg[HW_FRAG_LEN] > room || hw_reg[HW_FRAG_LEN] > MAX_FRAG) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_BAD_LENGTH;
                end else begin
                    total_next = hw_reg[HW_TOTAL];
                    seen_next  = '0;
                    sum_next   = 32'd0;
                    if (hw_reg[HW_FRAG_LEN] == 32'd0) begin
                        do_finish = 1'b1;
                    end else if (in_last) begin
                        do_fail     = 1'b1;
                        fail_status = STATUS_TRUNCATED;
                    end else begin
                        payload_next = 1'b1;
                    end
                end
            end else begin
                if (short_frag && in_last) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_TRUNCATED;
                end else begin
                    sum_next  = sum_new;
                    seen_next = seen_inc;
                    if (!short_frag) begin
                        do_finish = 1'b1;
                    end else begin
                        res_valid         = 1'b1;
                        res.payload_byte  = in_byte;
                        res.payload_valid = 1'b1;
                    end
                end
            end

            if (do_fail || do_finish) begin
                pos_next     = '0;
                payload_next = 1'b0;
                wa_next      = 32'd0;
                seen_next    = '0;
                sum_next     = 32'd0;
                discard_next = !fail_last;
            end

            if (do_fail) begin
                total_next = 32'd0;
                recv_next  = 32'd0;
                info_next  = 32'd0;
                res_valid  = 1'b1;
                res.status = fail_status;
            end

            if (do_finish) begin
                res.payload_byte  = payload_reg ? in_byte : 8'd0;
                res.payload_valid = payload_reg;
                if (!fin_ok) begin
                    total_next = 32'd0;
                    recv_next  = 32'd0;
                    info_next  = 32'd0;
                    res_valid  = 1'b1;
                    res.status = STATUS_BAD_CHECKSUM;
                end else if (fin_done) begin
                    total_next         = 32'd0;
                    recv_next          = 32'd0;
                    info_next          = 32'd0;
                    res_valid          = 1'b1;
                    res.message_done   = 1'b1;
                    res.message_info   = info_reg | hw_reg[HW_INFO];
                    res.message_length = fin_total;
                end else begin
                    total_next = fin_total;
                    recv_next  = fin_recv;
                    info_next  = info_reg | hw_reg[HW_INFO];
                    res_valid  = payload_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            payload_reg <= 1'b0;
            discard_reg <= 1'b0;
            wa_reg      <= 32'd0;
            seen_reg    <= '0;
            sum_reg     <= 32'd0;
            total_reg   <= 32'd0;
            recv_reg    <= 32'd0;
            info_reg    <= 32'd0;
        end else begin
            pos_reg     <= pos_next;
            payload_reg <= payload_next;
            discard_reg <= discard_next;
            wa_reg      <= wa_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            total_reg   <= total_next;
            recv_reg    <= recv_next;
            info_reg    <= info_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hw_we) begin
            hw_reg[pos_reg[4:2]] <= asm_word;
        end
    end

endmodule

FILE: design/fragment_deframer_checksum.sv
// ----------------------------------------------------------------------------
// fragment_deframer_checksum
// Parses framed fragments, forwards payload bytes and reports message
// completion or errors.
//
//   port group  dir  tdata (low bit up)                          tuser / tlast
//   s_*         in   data_byte[7:0]                              tlast frame_last
//   m_*         out  payload_byte, status, message_info, length  payload_valid, message_done
//   cfg_*       in   0 header_magic, 1 bytes_signed, 2 header_big_endian
//
// One item per cycle unless the output stalls: input register, parse logic,
// result register. The parse state updates as an item leaves the input
// register, so the input side stalls only while both registers are full.
// Reset is synchronous and clears all control state; no clearing pass.
// Quiet bytes give no result item; header bytes only report errors or message completion.
// ----------------------------------------------------------------------------
module fragment_deframer_checksum
    import fdc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte[7:0]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // payload_byte[7:0], status[10:8],
                                             // message_info[42:11], message_length[74:43]
    output logic [1:0]            m_tuser    // payload_valid[0], message_done[1]
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        m_valid_reg;
    fdc_result_t m_res_reg;
    logic        out_free;
    logic        step;
    logic        res_valid;
    fdc_result_t res;

    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    fdc_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.message_length, m_res_reg.message_info,
                       m_res_reg.status, m_res_reg.payload_byte};
    assign m_tuser  = {m_res_reg.message_done, m_res_reg.payload_valid};

    a_done_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.message_done |-> m_res_reg.status == STATUS_OK)
        else $error("completion reported with an error status");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.status != STATUS_OK |->
            !m_res_reg.message_done && m_res_reg.message_info == 32'd0 &&
            m_res_reg.message_length == 32'd0)
        else $error("error item carries message data");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_res_reg.payload_valid |-> m_res_reg.payload_byte == 8'd0)
        else $error("payload byte set without payload_valid");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_valid_reg && !m_tready |-> !s_tready && !step)
        else $error("item taken while both stages are full");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.payload_valid |->
            m_res_reg.status == STATUS_OK || m_res_reg.status == STATUS_BAD_CHECKSUM)
        else $error("forwarded byte with unexpected status");

endmodule
